// ===== hdl/lzss_pkg.sv =====
// Shared types and constants for the LZSS stream decompressor.
package lzss_pkg;

  // Default size of the history window in bytes.
  localparam int WINDOW_DEPTH_DEFAULT = 4096;

  // A match copies its high nibble plus this many bytes.
  localparam int MATCH_LEN_BIAS = 3;

  // Each flag byte governs this many items.
  localparam int FLAGS_PER_BYTE = 8;

  // Width of a compressed or decompressed byte.
  localparam int BYTE_W = 8;

  // Width of the output length carried in the header.
  localparam int LENGTH_W = 24;

  // Width of a match distance plus one.
  localparam int BACK_W = 13;

  // Width of the per-match copy counter.
  localparam int COPY_W = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;          // clear the stream state on a start word
    logic hdr_load;       // merge a header word into the length
    logic flag_load;      // load a new flag byte
    logic lit_emit;       // store and emit a literal word
    logic tok_high_load;  // keep the first word of a match token
    logic tok_load;       // decode the match length and distance
    logic copy_read;      // read one history byte for the match
    logic copy_emit;      // store and emit one copied byte
    logic next_flag;      // step to the next flag bit
  } lzss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_last;       // this header word is the final one
    logic hdr_len_zero;   // the length would be zero after this word
    logic flag_msb;       // current flag bit selects a match
    logic flags_last;     // current flag bit is the last of its byte
    logic rem_one;        // one output byte is left in the stream
    logic copy_last;      // one byte is left in the current match
    logic out_free;       // the output register can take a byte
  } lzss_status_t;

endpackage

// ===== hdl/lzss_stream_decompressor.sv =====
// Top level of the LZSS stream decompressor with a sliding history window.
//
// A stream opens with a start word carrying the type byte, then three length
// bytes (little-endian), then flag bytes read MSB first, each followed by up
// to eight literals or two-byte match tokens. Header, flag and literal words
// are taken whenever the output register is free, and a literal's byte goes
// straight into it. A match token takes two input words and then holds the
// input while its bytes (3 to 18) are copied one at a time, since every byte
// makes a registered read of the history memory and then a write back into
// it, which keeps overlapping copies exact. Bytes outside a
// stream are taken and dropped. Out-of-window references give a zero byte
// flagged as bad. No clearing pass is needed after reset.
module lzss_stream_decompressor #(
  parameter int WINDOW_DEPTH = lzss_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [lzss_pkg::BYTE_W-1:0] s_tdata,   // in_byte
  input  logic                        s_tuser,   // start_of_stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lzss_pkg::BYTE_W-1:0] m_tdata,   // out_byte
  output logic                        m_tlast,   // last_of_run
  output logic [1:0]                  m_tuser    // end_of_data, bad_reference
);

  lzss_pkg::lzss_cmd_t    cmd;
  lzss_pkg::lzss_status_t status;

  lzss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  lzss_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_byte  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== hdl/lzss_ctrl.sv =====
// Controller state machine for the LZSS stream decompressor.
module lzss_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  s_tuser,   // start_of_stream
  input  lzss_pkg::lzss_status_t status,
  output lzss_pkg::lzss_cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_HEADER  = 8'b0000_0010,
    ST_FLAG    = 8'b0000_0100,
    ST_ITEM    = 8'b0000_1000,
    ST_TOKEN   = 8'b0001_0000,
    ST_COPY_RD = 8'b0010_0000,
    ST_COPY_WR = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept_state;
  logic   in_fire;

  // Input words are taken in every state except while a match is copied, and only while the output register is free.
  assign accept_state = (state != ST_COPY_RD) && (state != ST_COPY_WR);
  assign s_tready     = accept_state && status.out_free;
  assign in_fire      = s_tvalid && s_tready;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    if (in_fire && s_tuser) begin
      cmd.start  = 1'b1;
      state_next = ST_HEADER;
    end else begin
      case (state)
        ST_HEADER: begin
          if (in_fire) begin
            cmd.hdr_load = 1'b1;
            if (status.hdr_last) begin
              state_next = status.hdr_len_zero ? ST_DONE : ST_FLAG;
            end
          end
        end
        ST_FLAG: begin
          if (in_fire) begin
            cmd.flag_load = 1'b1;
            state_next    = ST_ITEM;
          end
        end
        ST_ITEM: begin
          if (in_fire) begin
            if (!status.flag_msb) begin
              cmd.lit_emit = 1'b1;
              if (status.rem_one) begin
                state_next = ST_DONE;
              end else begin
                cmd.next_flag = 1'b1;
                state_next    = status.flags_last ? ST_FLAG : ST_ITEM;
              end
            end else begin
              cmd.tok_high_load = 1'b1;
              state_next        = ST_TOKEN;
            end
          end
        end
        ST_TOKEN: begin
          if (in_fire) begin
            cmd.tok_load = 1'b1;
            state_next   = ST_COPY_RD;
          end
        end
        ST_COPY_RD: begin
          cmd.copy_read = 1'b1;
          state_next    = ST_COPY_WR;
        end
        ST_COPY_WR: begin
          if (status.out_free) begin
            cmd.copy_emit = 1'b1;
            if (status.rem_one) begin
              state_next = ST_DONE;
            end else if (status.copy_last) begin
              cmd.next_flag = 1'b1;
              state_next    = status.flags_last ? ST_FLAG : ST_ITEM;
            end else begin
              state_next = ST_COPY_RD;
            end
          end
        end
        ST_IDLE, ST_DONE: begin
          state_next = state;
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A history read is always followed by the write half of the copy.
  a_read_then_write: assert property (@(posedge clk) disable iff (rst)
    cmd.copy_read |=> state == ST_COPY_WR)
    else $error("copy read not followed by copy write");

  // A match never starts without its second token word; later reads follow a write.
  a_copy_from_token: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY_RD) |-> ($past(state) == ST_TOKEN || $past(state) == ST_COPY_WR))
    else $error("copy entered without token");

  // No input word is taken while a match is being copied.
  a_no_input_in_copy: assert property (@(posedge clk) disable iff (rst)
    (cmd.copy_read || cmd.copy_emit) |-> !in_fire)
    else $error("input taken during copy");

endmodule

// ===== hdl/lzss_datapath.sv =====
// Datapath for the LZSS stream decompressor: counters, history and output register.
module lzss_datapath #(
  parameter int WINDOW_DEPTH = lzss_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lzss_pkg::lzss_cmd_t          cmd,
  output lzss_pkg::lzss_status_t       status,
  input  logic [lzss_pkg::BYTE_W-1:0]  in_byte,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lzss_pkg::BYTE_W-1:0]  m_tdata,   // out_byte
  output logic                         m_tlast,   // last_of_run
  output logic [1:0]                   m_tuser    // end_of_data, bad_reference
);

  localparam int PW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int DW = PW + 1;
  localparam int BW = lzss_pkg::BYTE_W;
  localparam int LW = lzss_pkg::LENGTH_W;
  localparam int KW = lzss_pkg::BACK_W;
  localparam int NW = lzss_pkg::COPY_W;

  logic [1:0]    header_index;
  logic [LW-1:0] remaining_length;
  logic [BW-1:0] flag_bits;
  logic [3:0]    flags_left;
  logic [BW-1:0] token_high;
  logic [PW-1:0] write_position;
  logic [CW-1:0] produced_count;
  logic [KW-1:0] back;
  logic [NW-1:0] copy_count;
  logic [BW-1:0] rd_data;
  logic [BW-1:0] history [WINDOW_DEPTH];

  logic [DW-1:0] addr_diff;
  logic [PW-1:0] rd_addr;
  logic          bad;
  logic          store;
  logic [BW-1:0] store_byte;
  logic          out_valid;
  logic [BW-1:0] out_byte;
  logic          out_last;
  logic          out_end;
  logic          out_bad;

  // Status toward the controller.
  assign status.hdr_last     = header_index == 2'd3;
  assign status.hdr_len_zero = (remaining_length == '0) && (in_byte == '0);
  assign status.flag_msb     = flag_bits[BW-1];
  assign status.flags_last   = flags_left == 4'd1;
  assign status.rem_one      = remaining_length == LW'(1);
  assign status.copy_last    = copy_count == NW'(1);
  assign status.out_free     = !out_valid || m_tready;

  // Source address of a copy: wrap the difference back into the window.
  assign addr_diff = {1'b0, write_position} - DW'(back);
  assign rd_addr   = addr_diff[DW-1] ? PW'(addr_diff + DW'(WINDOW_DEPTH))
                                     : addr_diff[PW-1:0];

  // A distance beyond what this stream has produced reads as zero.
  assign bad        = CW'(back) > produced_count;
  assign store      = cmd.lit_emit || cmd.copy_emit;
  assign store_byte = cmd.lit_emit ? in_byte : (bad ? '0 : rd_data);

  // Stream, flag and match bookkeeping.
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      header_index     <= rst ? 2'd0 : 2'd1;
      remaining_length <= '0;
      flag_bits        <= '0;
      flags_left       <= '0;
      token_high       <= '0;
      write_position   <= '0;
      produced_count   <= '0;
      back             <= '0;
      copy_count       <= '0;
    end else begin
      if (cmd.hdr_load) begin
        case (header_index)
          2'd1:    remaining_length[7:0]   <= in_byte;
          2'd2:    remaining_length[15:8]  <= in_byte;
          default: remaining_length[23:16] <= remaining_length[23:16] | in_byte;
        endcase
        header_index <= status.hdr_last ? 2'd0 : header_index + 2'd1;
      end
      if (cmd.flag_load) begin
        flag_bits  <= in_byte;
        flags_left <= 4'(lzss_pkg::FLAGS_PER_BYTE);
      end
      if (cmd.next_flag) begin
        flag_bits  <= {flag_bits[BW-2:0], 1'b0};
        flags_left <= flags_left - 4'd1;
      end
      if (cmd.tok_high_load) begin
        token_high <= in_byte;
      end
      if (cmd.tok_load) begin
        back       <= {1'b0, token_high[3:0], in_byte} + KW'(1);
        copy_count <= NW'(token_high[7:4]) + NW'(lzss_pkg::MATCH_LEN_BIAS);
      end
      if (cmd.copy_emit) begin
        copy_count <= copy_count - NW'(1);
      end
      if (store) begin
        write_position   <= (write_position == PW'(WINDOW_DEPTH - 1)) ? '0
                                                                      : write_position + 1'b1;
        if (produced_count != CW'(WINDOW_DEPTH)) begin
          produced_count <= produced_count + 1'b1;
        end
        remaining_length <= remaining_length - LW'(1);
      end
    end
  end

  // History memory: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (store) begin
      history[write_position] <= store_byte;
    end
    if (cmd.copy_read) begin
      rd_data <= history[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= store || (out_valid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      out_byte <= store_byte;
      out_last <= cmd.lit_emit || status.copy_last || status.rem_one;
      out_end  <= status.rem_one;
      out_bad  <= cmd.copy_emit && bad;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;
  assign m_tuser  = {out_bad, out_end};

  // A byte is only produced when the output register can take it.
  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    store |-> (!out_valid || m_tready))
    else $error("output word overwritten");

  // A bad reference always delivers a zero byte.
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_bad) |-> out_byte == '0)
    else $error("bad reference with nonzero byte");

  // The final byte of a stream also closes its run.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_end) |-> out_last)
    else $error("end of data without last of run");

  // Counters stay inside the window.
  a_window_bounds: assert property (@(posedge clk) disable iff (rst)
    (write_position <= PW'(WINDOW_DEPTH - 1)) && (produced_count <= CW'(WINDOW_DEPTH)))
    else $error("history counters out of range");

endmodule

// ===== bench/lzss_stream_checker.sv =====
`timescale 1ns / 100ps
// Checker that decodes the accepted input words itself and compares the block output with it.
module lzss_stream_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [lzss_pkg::BYTE_W-1:0] s_tdata,   // in_byte
  input  logic                        s_tuser,   // start_of_stream
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [lzss_pkg::BYTE_W-1:0] m_tdata,   // out_byte
  input  logic                        m_tlast,   // last_of_run
  input  logic [1:0]                  m_tuser,   // end_of_data, bad_reference
  output int                          fail_count,
  output int                          pending_words
);
  import lzss_pkg::*;

  localparam int WIN = WINDOW_DEPTH_DEFAULT;
  localparam int PTR_W = $clog2(WIN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEADER,
    ST_FLAG,
    ST_ITEM,
    ST_TOKEN,
    ST_DONE
  } dec_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              eod;
    logic              bad;
  } out_word_t;

  // Decoder state kept alongside the block.
  dec_state_t          st;
  logic [1:0]          hdr_idx;
  logic [LENGTH_W-1:0] rem_len;
  logic [7:0]          flags;
  logic [3:0]          flags_left;
  logic [7:0]          tok_hi;
  logic [PTR_W-1:0]    wr_pos;
  logic [PTR_W:0]      produced;
  logic [7:0]          history [WIN];

  out_word_t expected_out[$];
  int        errors = 0;

  // Writes one decoded byte into the window and queues it as an expected word.
  task automatic put_byte(input logic [7:0] v, input logic bad);
    history[wr_pos] = v;
    wr_pos = wr_pos + 1'b1;
    if (produced < WIN) produced = produced + 1'b1;
    rem_len = rem_len - 1'b1;
    expected_out.push_back('{data: v, last: 1'b0, eod: (rem_len == 0), bad: bad});
  endtask

  // Moves on to the next flag bit, or to a new flag byte after eight items.
  task automatic advance_flag();
    flags = flags << 1;
    flags_left = flags_left - 1'b1;
    st = (flags_left == 0) ? ST_FLAG : ST_ITEM;
  endtask

  // Decodes one accepted input word and queues the output words it causes.
  task automatic decode_word(input logic [7:0] b, input logic sos);
    int               first;
    int               span;
    int               i;
    logic [BACK_W-1:0] back;
    logic [PTR_W-1:0] src;
    logic [7:0]       v;
    logic             bad;
    out_word_t        w;
    first = expected_out.size();
    if (sos) begin
      st = ST_HEADER;
      hdr_idx = 2'd1;
      rem_len = '0;
      flags = '0;
      flags_left = '0;
      tok_hi = '0;
      wr_pos = '0;
      produced = '0;
    end else begin
      case (st)
        ST_HEADER: begin
          rem_len = rem_len | (LENGTH_W'(b) << (8 * (int'(hdr_idx) - 1)));
          if (hdr_idx == 2'd3) begin
            hdr_idx = '0;
            st = (rem_len == 0) ? ST_DONE : ST_FLAG;
          end else begin
            hdr_idx = hdr_idx + 1'b1;
          end
        end
        ST_FLAG: begin
          flags = b;
          flags_left = 4'(FLAGS_PER_BYTE);
          st = ST_ITEM;
        end
        ST_ITEM: begin
          if (!flags[7]) begin
            put_byte(b, 1'b0);
            if (rem_len == 0) st = ST_DONE;
            else advance_flag();
          end else begin
            tok_hi = b;
            st = ST_TOKEN;
          end
        end
        ST_TOKEN: begin
          span = int'(tok_hi[7:4]) + MATCH_LEN_BIAS;
          back = {1'b0, tok_hi[3:0], b} + 1'b1;
          // Byte by byte, so a copy may read what it has just written.
          for (i = 0; i < span; i++) begin
            bad = back > produced;
            src = wr_pos - back[PTR_W-1:0];
            v = bad ? 8'h00 : history[src];
            put_byte(v, bad);
            if (rem_len == 0) break;
          end
          if (rem_len == 0) st = ST_DONE;
          else advance_flag();
        end
        default: begin
        end
      endcase
    end
    if (expected_out.size() > first) begin
      w = expected_out.pop_back();
      w.last = 1'b1;
      expected_out.push_back(w);
    end
  endtask

  // Both channels are sampled at the clock edge; inputs are decoded before outputs are checked.
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (rst) begin
      st = ST_IDLE;
      hdr_idx = '0;
      rem_len = '0;
      flags = '0;
      flags_left = '0;
      tok_hi = '0;
      wr_pos = '0;
      produced = '0;
    end else begin
      if (s_tvalid && s_tready) decode_word(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        got = '{data: m_tdata, last: m_tlast, eod: m_tuser[0], bad: m_tuser[1]};
        if (expected_out.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual data=%h last=%b end=%b bad=%b",
                   $time, got.data, got.last, got.eod, got.bad);
        end else begin
          want = expected_out.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch: exp data=%h last=%b end=%b bad=%b, act %h %b %b %b",
                     $time, want.data, want.last, want.eod, want.bad,
                     got.data, got.last, got.eod, got.bad);
          end
        end
      end
    end
    fail_count <= errors;
    pending_words <= expected_out.size();
  end

endmodule

// ===== bench/tb_lzss_stream_decompressor.sv =====
`timescale 1ns / 100ps
// Top of the decompressor testbench: clock, reset, compressed stream stimulus and verdict.
module tb_lzss_stream_decompressor;
  import lzss_pkg::*;

  localparam int WIN = WINDOW_DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEM_COUNT = 170;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [BYTE_W-1:0] s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [BYTE_W-1:0] m_tdata;
  logic              m_tlast;
  logic [1:0]        m_tuser;

  int         fail_count;
  int         pending_words;
  int         cycles = 0;
  int         sent_words = 0;
  logic       steady = 1'b0;
  logic [7:0] burst[$];

  lzss_stream_decompressor dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  lzss_stream_checker u_checker (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .fail_count(fail_count),
    .pending_words(pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The output side stalls at random except during the steady stretch.
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 15);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("lzss_stream_decompressor regression: fail");
      $finish;
    end
  end

  // Offers one word, with random gaps in front of it outside the steady stretch, and waits for it to be taken.
  task automatic send_word(input logic [7:0] b, input logic sos);
    if (!steady) begin
      while ($urandom_range(0, 99) < 15) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= sos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_words++;
  endtask

  // Sends the queued stream; its first word carries the start mark.
  task automatic send_burst();
    foreach (burst[i]) send_word(burst[i], i == 0);
  endtask

  // Builds a well-formed stream of the given output length.
  // With long_copies set it favors maximal matches; past the first, they reach only bytes already made.
  task automatic make_stream(input int len, input bit long_copies);
    int          made;
    int          nib;
    int          reach;
    int          i;
    logic [7:0]  flag;
    logic [23:0] len24;
    len24 = 24'(len);
    burst.delete();
    burst.push_back(8'($urandom));
    burst.push_back(len24[7:0]);
    burst.push_back(len24[15:8]);
    burst.push_back(len24[23:16]);
    made = 0;
    while (made < len) begin
      flag = long_copies ? 8'($urandom | $urandom) : 8'($urandom);
      burst.push_back(flag);
      for (i = 7; i >= 0 && made < len; i--) begin
        if (flag[i]) begin
          nib = long_copies ? 15 : $urandom_range(0, 15);
          // Mostly valid distances; now and then one that reaches before the stream.
          if (made == 0 || (!long_copies && $urandom_range(0, 99) < 8))
            reach = $urandom_range(0, WIN - 1);
          else
            reach = $urandom_range(0, ((made < WIN) ? made : WIN) - 1);
          burst.push_back({4'(nib), 4'(reach >> 8)});
          burst.push_back(8'(reach));
          made += nib + MATCH_LEN_BIAS;
        end else begin
          burst.push_back(8'($urandom));
          made++;
        end
      end
    end
  endtask

  initial begin
    int pick;
    int cut;
    bit big_done;
    big_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // A word while idle is dropped.
    send_word(8'hA5, 1'b0);
    // Zero length, then a word after the stream has ended.
    burst = '{8'h10, 8'h00, 8'h00, 8'h00, 8'h5A};
    send_burst();
    // Longest match as the first item: bad reference, and the length runs out mid-copy.
    burst = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h80, 8'hF0, 8'h07};
    send_burst();
    // Largest length, cut short by the next start.
    burst = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_burst();
    // Two literals, then a match of the farthest distance ending the stream at once.
    burst = '{8'h7E, 8'h03, 8'h00, 8'h00, 8'h20, 8'h12, 8'h34, 8'h0F, 8'hFF};
    send_burst();
    // Overlapping copy of the byte just written.
    burst = '{8'h01, 8'h07, 8'h00, 8'h00, 8'h40, 8'hFF, 8'h10, 8'h00};
    send_burst();

    // Random streams, one longer stream of maximal matches, some broken or padded.
    while (sent_words < ITEM_COUNT) begin
      if (!big_done && sent_words >= ITEM_COUNT / 3) begin
        steady = 1'b1;
        make_stream($urandom_range(400, 500), 1'b1);
        send_burst();
        steady = 1'b0;
        big_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        make_stream((pick < 5) ? 0 : $urandom_range(1, 48), 1'b0);
        if (pick >= 5 && pick < 15 && burst.size() > 1) begin
          cut = $urandom_range(1, burst.size() - 1);
          while (burst.size() > cut) void'(burst.pop_back());
        end
        if (pick >= 15 && pick < 25)
          repeat ($urandom_range(1, 3)) burst.push_back(8'($urandom));
        send_burst();
      end
    end
    s_tvalid <= 1'b0;

    // Drain the outstanding words, then allow the block to settle.
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("lzss_stream_decompressor regression: pass");
    end else begin
      $display("lzss_stream_decompressor regression: fail");
    end
    $finish;
  end

endmodule
